>>> rtl/bha_pkg.sv
// Package for the buddy heap allocator: sizes, status and opcode codes,
// and the configuration bundle. No dependencies.
`timescale 1ns / 1ps
package bha_pkg;

  localparam int NUM_FRAMES       = 256;
  localparam int FRAME_BYTES      = 4096;
  localparam int FIRST_FREE_FRAME = 16;
  localparam int STACK_RESET      = (NUM_FRAMES > FIRST_FREE_FRAME) ?
                                    (NUM_FRAMES - FIRST_FREE_FRAME) : 0;
  localparam int SLOTS            = FRAME_BYTES / 32;
  localparam int CNT_W            = 9;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_BIG     = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_ALIGN   = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_CORRUPT = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    REG_MEMORY_BASE = 1'b0,
    REG_MAX_ALLOC   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [31:0] memory_base;
    logic [11:0] max_alloc_bytes;
  } cfg_t;

endpackage

>>> rtl/bha_engine.sv
// Allocation engine: request sequencer over the header, frame list, mask
// and free-frame stack memories. Depends on bha_pkg.
`timescale 1ns / 1ps
module bha_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bha_pkg::cfg_t      cfg_i,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [15:0]        alloc_size_i,
  input  logic [31:0]        free_address_i,
  output logic               done_o,
  output logic [31:0]        result_address_o,
  output logic [2:0]         status_o,
  output logic [8:0]         heap_frame_count_o
);
  import bha_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CHECK   = 18'h00002,
    S_SRCH    = 18'h00004,
    S_POP_RD  = 18'h00008,
    S_POP_WR  = 18'h00010,
    S_ID_RD   = 18'h00020,
    S_ID_WAIT = 18'h00040,
    S_WALK_RD = 18'h00080,
    S_WALK_EV = 18'h00100,
    S_SPLIT   = 18'h00200,
    S_RB_RD   = 18'h00400,
    S_RB_EV   = 18'h00800,
    S_FH_RD   = 18'h01000,
    S_FH_EV   = 18'h02000,
    S_MG_RD   = 18'h04000,
    S_MG_EV   = 18'h08000,
    S_SH_RD   = 18'h10000,
    S_SH_WR   = 18'h20000
  } state_e;

  // Memories
  logic [3:0] hdr_mem [NUM_FRAMES*SLOTS];
  logic [7:0] ids_mem [NUM_FRAMES];
  logic [7:0] msk_mem [NUM_FRAMES];
  logic [7:0] stk_mem [NUM_FRAMES];

  logic [14:0] hdr_ra, hdr_wa;
  logic [3:0]  hdr_wd, hdr_rd_q;
  logic        hdr_we;
  logic [7:0]  ids_ra, ids_wa, ids_wd, ids_rd_q;
  logic        ids_we;
  logic [7:0]  msk_ra, msk_wa, msk_wd, msk_rd_q;
  logic        msk_we;
  logic [7:0]  stk_ra, stk_wa, stk_wd, stk_rd_q;
  logic        stk_we;

  // Control and working registers
  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [15:0] size_q, size_d;
  logic [31:0] faddr_q, faddr_d;
  logic [2:0]  lg_q, lg_d, match_q, match_d, lvl_q, lvl_d;
  logic [12:0] off_q, off_d;
  logic [7:0]  frame_q, frame_d, slot_q, slot_d, pidx_q, pidx_d;
  logic [8:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d, found_q, found_d;
  logic [3:0]  best_q, best_d;
  logic [7:0]  acc_q, acc_d;
  logic [19:0] fid_q, fid_d;
  logic [31:0] res_q, res_d;
  logic [8:0]  total_q, total_d, depth_q, depth_d, low_q, low_d;
  logic        done_q;
  logic [31:0] out_addr_q;
  status_e     out_st_q;

  logic        fin;
  status_e     fin_st;
  logic [31:0] fin_addr;

  // Lowest set bit of a mask, 8 when empty.
  function automatic logic [3:0] low_bit(input logic [7:0] m);
    logic [3:0] r;
    r = 4'd8;
    for (int b = 7; b >= 0; b--) begin
      if (m[b]) r = 4'(b);
    end
    return r;
  endfunction

  // Size code of the smallest chunk that holds the bytes plus a header byte.
  function automatic logic [2:0] size_code(input logic [15:0] s);
    logic [2:0] r;
    r = 3'd0;
    for (int b = 1; b < 8; b++) begin
      if (s >= (16'd16 << b)) r = 3'(b);
    end
    return r;
  endfunction

  logic [11:0] buddy;
  logic [31:0] rel;
  logic [11:0] ins_m1;
  logic [7:0]  mmask;
  logic [3:0]  mlow;
  logic [12:0] step;
  logic [12:0] noff;
  logic [7:0]  nacc;
  logic [7:0]  pop_frame;
  logic [8:0]  pop_k;

  assign buddy  = off_q[11:0] ^ (12'd32 << lvl_q);
  assign rel    = faddr_q - cfg_i.memory_base;
  assign ins_m1 = rel[11:0] - 12'd1;
  assign mmask  = msk_rd_q & (8'hFF << lg_q);
  assign mlow   = low_bit(mmask);
  assign step   = 13'd32 << hdr_rd_q[2:0];
  assign noff   = off_q + step;
  assign nacc   = hdr_rd_q[3] ? acc_q : (acc_q | (8'd1 << hdr_rd_q[2:0]));
  assign pop_k  = depth_q;
  assign pop_frame = (pop_k >= low_q) ? stk_rd_q : 8'(FIRST_FREE_FRAME + int'(pop_k));

  // Sequencer
  always_comb begin
    state_d = state_q;  op_d = op_q;  size_d = size_q;  faddr_d = faddr_q;
    lg_d = lg_q;  match_d = match_q;  lvl_d = lvl_q;  off_d = off_q;
    frame_d = frame_q;  slot_d = slot_q;  pidx_d = pidx_q;  cnt_d = cnt_q;
    pend_d = pend_q;  found_d = found_q;  best_d = best_q;  acc_d = acc_q;
    fid_d = fid_q;  res_d = res_q;  total_d = total_q;  depth_d = depth_q;
    low_d = low_q;
    hdr_ra = {frame_q, off_q[11:5]};  hdr_we = 1'b0;
    hdr_wa = {frame_q, off_q[11:5]};  hdr_wd = 4'd0;
    ids_ra = cnt_q[7:0];  ids_we = 1'b0;  ids_wa = cnt_q[7:0];  ids_wd = 8'd0;
    msk_ra = cnt_q[7:0];  msk_we = 1'b0;  msk_wa = cnt_q[7:0];  msk_wd = 8'd0;
    stk_ra = 8'(depth_q - 9'd1);  stk_we = 1'b0;  stk_wa = depth_q[7:0];
    stk_wd = fid_q[7:0];
    fin = 1'b0;  fin_st = ST_OK;  fin_addr = 32'd0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = op_e'(op_i);
          size_d  = alloc_size_i;
          faddr_d = free_address_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d   = '0;
        pend_d  = 1'b0;
        found_d = 1'b0;
        best_d  = 4'd8;
        if (op_q == OP_ALLOC) begin
          lg_d = size_code(size_q);
          if (size_q == 16'd0) begin
            fin = 1'b1;  fin_st = ST_ZERO;  state_d = S_IDLE;
          end else if (size_q > {4'd0, cfg_i.max_alloc_bytes}) begin
            fin = 1'b1;  fin_st = ST_BIG;  state_d = S_IDLE;
          end else begin
            state_d = S_SRCH;
          end
        end else begin
          fid_d = rel[31:12];
          off_d = {1'b0, ins_m1};
          if (faddr_q == 32'd0) begin
            fin = 1'b1;  state_d = S_IDLE;
          end else if (rel[11:0] == 12'd0 || ins_m1[4:0] != 5'd0) begin
            fin = 1'b1;  fin_st = ST_ALIGN;  state_d = S_IDLE;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      // Stream through the frame list, one entry a cycle.
      S_SRCH: begin
        if (cnt_q < total_q) begin
          pend_d = 1'b1;  pidx_d = cnt_q[7:0];  cnt_d = cnt_q + 9'd1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (op_q == OP_ALLOC) begin
            if (mlow < best_q) begin
              best_d = mlow;  slot_d = pidx_q;
            end
          end else if (!found_q && ids_rd_q == fid_q[7:0] && fid_q[19:8] == 12'd0) begin
            found_d = 1'b1;  slot_d = pidx_q;
          end
        end
        if (cnt_q >= total_q && !pend_q) begin
          if (op_q == OP_ALLOC) begin
            if (best_q < 4'd8) begin
              match_d = best_q[2:0];  state_d = S_ID_RD;
            end else if (depth_q == 9'd0 || total_q >= 9'(NUM_FRAMES)) begin
              fin = 1'b1;  fin_st = ST_NOFRAME;  state_d = S_IDLE;
            end else begin
              depth_d = depth_q - 9'd1;  state_d = S_POP_RD;
            end
          end else if (!found_q) begin
            fin = 1'b1;  fin_st = ST_UNKNOWN;  state_d = S_IDLE;
          end else begin
            frame_d = fid_q[7:0];  state_d = S_FH_RD;
          end
        end
      end
      S_POP_RD: begin
        stk_ra  = depth_q[7:0];
        state_d = S_POP_WR;
      end
      // Take a fresh frame into the heap as one free 4096-byte chunk.
      S_POP_WR: begin
        if (pop_k < low_q) low_d = pop_k;
        frame_d = pop_frame;
        slot_d  = total_q[7:0];
        total_d = total_q + 9'd1;
        ids_we  = 1'b1;  ids_wa = total_q[7:0];  ids_wd = pop_frame;
        msk_we  = 1'b1;  msk_wa = total_q[7:0];  msk_wd = 8'h80;
        hdr_we  = 1'b1;  hdr_wa = {pop_frame, 7'd0};  hdr_wd = 4'd7;
        match_d = 3'd7;
        off_d   = '0;
        state_d = S_WALK_RD;
      end
      S_ID_RD: begin
        ids_ra  = slot_q;
        state_d = S_ID_WAIT;
      end
      S_ID_WAIT: begin
        frame_d = ids_rd_q;
        off_d   = '0;
        state_d = S_WALK_RD;
      end
      S_WALK_RD: state_d = S_WALK_EV;
      // Find the first free chunk of the matching size.
      S_WALK_EV: begin
        if (!hdr_rd_q[3] && hdr_rd_q[2:0] == match_q) begin
          lvl_d = match_q;  state_d = S_SPLIT;
        end else if (noff >= 13'(FRAME_BYTES)) begin
          fin = 1'b1;  fin_st = ST_CORRUPT;  state_d = S_IDLE;
        end else begin
          off_d = noff;  state_d = S_WALK_RD;
        end
      end
      // Halve the chunk one level a cycle, then mark it allocated.
      S_SPLIT: begin
        hdr_we = 1'b1;
        if (lvl_q > lg_q) begin
          hdr_wa = {frame_q, 7'(off_q[11:5] + (7'd1 << (lvl_q - 3'd1)))};
          hdr_wd = {1'b0, lvl_q - 3'd1};
          lvl_d  = lvl_q - 3'd1;
        end else begin
          hdr_wd  = {1'b1, lg_q};
          res_d   = cfg_i.memory_base + {12'd0, frame_q, 12'd0} +
                    {20'd0, off_q[11:0]} + 32'd1;
          off_d   = '0;
          acc_d   = '0;
          state_d = S_RB_RD;
        end
      end
      S_RB_RD: state_d = S_RB_EV;
      // Rebuild the free-size mask of the frame from its chunk chain.
      S_RB_EV: begin
        if (noff == 13'(FRAME_BYTES)) begin
          msk_we = 1'b1;  msk_wa = slot_q;  msk_wd = nacc;
          fin = 1'b1;
          fin_addr = (op_q == OP_ALLOC) ? res_q : 32'd0;
          state_d = S_IDLE;
        end else if (noff > 13'(FRAME_BYTES)) begin
          fin = 1'b1;  fin_st = ST_CORRUPT;  state_d = S_IDLE;
        end else begin
          acc_d = nacc;  off_d = noff;  state_d = S_RB_RD;
        end
      end
      S_FH_RD: state_d = S_FH_EV;
      S_FH_EV: begin
        hdr_we = 1'b1;  hdr_wd = {1'b0, hdr_rd_q[2:0]};
        lvl_d  = hdr_rd_q[2:0];
        cnt_d  = {1'b0, slot_q};
        state_d = (hdr_rd_q[2:0] == 3'd7) ? S_SH_RD : S_MG_RD;
      end
      S_MG_RD: begin
        hdr_ra  = {frame_q, buddy[11:5]};
        state_d = S_MG_EV;
      end
      // Merge with a free buddy of equal size, one level at a time.
      S_MG_EV: begin
        if (hdr_rd_q != {1'b0, lvl_q}) begin
          off_d = '0;  acc_d = '0;  state_d = S_RB_RD;
        end else if (lvl_q == 3'd6) begin
          state_d = S_SH_RD;
        end else begin
          off_d  = {1'b0, off_q[11:0] & buddy};
          hdr_we = 1'b1;
          hdr_wa = {frame_q, off_q[11:5] & buddy[11:5]};
          hdr_wd = {1'b0, lvl_q + 3'd1};
          lvl_d  = lvl_q + 3'd1;
          state_d = S_MG_RD;
        end
      end
      // Close the gap in the frame list, then return the frame to the stack.
      S_SH_RD: begin
        ids_ra = 8'(cnt_q + 9'd1);
        msk_ra = 8'(cnt_q + 9'd1);
        if (cnt_q + 9'd1 < total_q) begin
          state_d = S_SH_WR;
        end else begin
          total_d = total_q - 9'd1;
          if (depth_q < 9'(NUM_FRAMES)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + 9'd1;
          end
          fin = 1'b1;  state_d = S_IDLE;
        end
      end
      S_SH_WR: begin
        ids_we = 1'b1;  ids_wd = ids_rd_q;
        msk_we = 1'b1;  msk_wd = msk_rd_q;
        cnt_d  = cnt_q + 9'd1;
        state_d = S_SH_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (ids_we) ids_mem[ids_wa] <= ids_wd;
    if (msk_we) msk_mem[msk_wa] <= msk_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    hdr_rd_q <= hdr_mem[hdr_ra];
    ids_rd_q <= ids_mem[ids_ra];
    msk_rd_q <= msk_mem[msk_ra];
    stk_rd_q <= stk_mem[stk_ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      depth_q <= 9'(STACK_RESET);
      low_q   <= 9'(STACK_RESET);
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      depth_q <= depth_d;
      low_q   <= low_d;
      pend_q  <= pend_d;
      done_q  <= fin;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;  size_q <= size_d;  faddr_q <= faddr_d;
    lg_q <= lg_d;  match_q <= match_d;  lvl_q <= lvl_d;  off_q <= off_d;
    frame_q <= frame_d;  slot_q <= slot_d;  pidx_q <= pidx_d;  cnt_q <= cnt_d;
    found_q <= found_d;  best_q <= best_d;  acc_q <= acc_d;  fid_q <= fid_d;
    res_q <= res_d;
    if (fin) begin
      out_addr_q <= fin_addr;
      out_st_q   <= fin_st;
    end
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign result_address_o   = out_addr_q;
  assign status_o           = out_st_q;
  assign heap_frame_count_o = total_q;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= 9'(NUM_FRAMES)) else $error("frame list overflow");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 9'(NUM_FRAMES)) else $error("stack overflow");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result shown while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_q) else $error("request not taken");
`endif

endmodule

>>> rtl/buddy_heap_allocator_top.sv
// Top level of the buddy heap allocator: register port and the engine.
// Depends on bha_pkg and bha_engine.
//
//   channel   | signals                                   | transfer
//   request   | start, busy, op_i, alloc_size_i, free_... | start && !busy
//   result    | done_o, result_address_o, status_o, ...   | done_o, one cycle
//   registers | psel, penable, pwrite, paddr, pwdata, ... | access phase
//
// One request at a time: a check, a scan of the frame list, then for an
// allocation a fetch or pop of the frame, a walk of its headers, one halving
// per level plus a mark, and a rebuild of the mask; a free reads its header,
// merges level by level, then rebuilds the mask or shifts the later list
// entries down. The result strobe follows in the next cycle.
// Reset leaves the heap empty and the free-frame stack full; there is no clearing
// pass. Results cannot be stalled.
`timescale 1ns / 1ps
module buddy_heap_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [15:0] alloc_size_i,
  input  logic [31:0] free_address_i,
  output logic        done_o,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o,
  output logic [8:0]  heap_frame_count_o
);
  import bha_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_base     <= 32'd0;
      cfg_q.max_alloc_bytes <= 12'hFFF;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MEMORY_BASE: cfg_q.memory_base     <= pwdata;
        REG_MAX_ALLOC:   cfg_q.max_alloc_bytes <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      REG_MEMORY_BASE: prdata = cfg_q.memory_base;
      REG_MAX_ALLOC:   prdata = {20'd0, cfg_q.max_alloc_bytes};
      default:         prdata = 32'd0;
    endcase
  end

  bha_engine u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .start              (start),
    .busy               (busy),
    .op_i               (op_i),
    .alloc_size_i       (alloc_size_i),
    .free_address_i     (free_address_i),
    .done_o             (done_o),
    .result_address_o   (result_address_o),
    .status_o           (status_o),
    .heap_frame_count_o (heap_frame_count_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for buddy_heap_allocator_top: a table of directed
// requests, then randomised phases, each request checked against a predictor
// or a typed-in outcome. Depends on bha_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb;
  import bha_pkg::*;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  st;
    logic [8:0]  cnt;
  } outcome_t;

  typedef struct {
    op_e         op;
    int          size;
    logic [31:0] addr;
    bit          free_last;
    bit          typed;
    outcome_t    want;
  } row_t;

  typedef struct {
    int frame;
    int off;
  } chunk_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start, busy, op_i, done_o;
  logic [15:0] alloc_size_i;
  logic [31:0] free_address_i, result_address_o;
  logic [2:0]  status_o;
  logic [8:0]  heap_frame_count_o;

  buddy_heap_allocator_top u_dut (.*);

  // Predicted heap state and register copies.
  logic [3:0]  hdr_mem [NUM_FRAMES*SLOTS];
  int          frame_list [NUM_FRAMES];
  logic [7:0]  size_mask [NUM_FRAMES];
  int          frame_total;
  int          spare_stack [NUM_FRAMES];
  int          spare_depth;
  logic [31:0] cfg_base;
  int          cfg_max;

  outcome_t outcome_q[$];
  chunk_t   live_q[$];
  chunk_t   seen_q[$];
  row_t     rows[$];
  int       errors, mismatches, burst_left;

  function automatic int hidx(int frame, int off);
    return (frame % NUM_FRAMES) * SLOTS + ((off >> 5) & (SLOTS - 1));
  endfunction

  // Walk the chunk chain of one heap frame and refresh its free-size mask.
  function automatic bit mask_rebuild(int slot);
    int         frame;
    int         off;
    logic [7:0] m;
    logic [3:0] h;
    frame = frame_list[slot];
    off = 0;
    m = '0;
    while (1) begin
      h = hdr_mem[hidx(frame, off)];
      if (!h[3]) m[h[2:0]] = 1'b1;
      off += 32 << h[2:0];
      if (off == FRAME_BYTES) begin
        size_mask[slot] = m;
        return 1'b1;
      end
      if (off > FRAME_BYTES) return 1'b0;
    end
  endfunction

  function automatic status_e heap_alloc(int size, output logic [31:0] addr);
    int         lg, j, i, slot, match, frame, off;
    bit         found;
    logic [3:0] h;
    addr = '0;
    slot = 0;
    match = 0;
    found = 0;
    if (size == 0) return ST_ZERO;
    if (size > cfg_max) return ST_BIG;
    lg = 7;
    while (lg > 0 && size < (16 << lg)) lg--;
    for (j = lg; j < 8 && !found; j++)
      for (i = 0; i < frame_total; i++)
        if (size_mask[i][j]) begin
          found = 1;
          slot = i;
          match = j;
          break;
        end
    // No frame has room, so a fresh frame comes off the spare stack.
    if (!found) begin
      if (spare_depth == 0 || frame_total >= NUM_FRAMES) return ST_NOFRAME;
      spare_depth--;
      frame = spare_stack[spare_depth];
      slot = frame_total;
      frame_total++;
      frame_list[slot] = frame;
      size_mask[slot] = 8'h80;
      hdr_mem[hidx(frame, 0)] = 4'd7;
      match = 7;
    end
    frame = frame_list[slot];
    off = 0;
    while (1) begin
      h = hdr_mem[hidx(frame, off)];
      if (!h[3] && h[2:0] == match) break;
      off += 32 << h[2:0];
      if (off >= FRAME_BYTES) return ST_CORRUPT;
    end
    // Halve the chunk down to the needed size.
    for (i = match; i > lg; i--) hdr_mem[hidx(frame, off + (32 << (i - 1)))] = 4'(i - 1);
    hdr_mem[hidx(frame, off)] = {1'b1, lg[2:0]};
    if (!mask_rebuild(slot)) return ST_CORRUPT;
    addr = cfg_base + frame * FRAME_BYTES + off + 1;
    return ST_OK;
  endfunction

  function automatic status_e heap_free(logic [31:0] address);
    logic [31:0] rel;
    int          in_frame, off, fid, i, slot, lg, buddy;
    bit          found, give;
    if (address == 0) return ST_OK;
    rel = address - cfg_base;
    in_frame = rel[11:0];
    if (in_frame == 0 || ((in_frame - 1) & 31) != 0) return ST_ALIGN;
    off = in_frame - 1;
    fid = rel[31:12];
    found = 0;
    slot = 0;
    for (i = 0; i < frame_total; i++)
      if (frame_list[i] == fid) begin
        found = 1;
        slot = i;
        break;
      end
    if (!found) return ST_UNKNOWN;
    lg = hdr_mem[hidx(fid, off)][2:0];
    hdr_mem[hidx(fid, off)] = 4'(lg);
    give = (lg == 7);
    // Merge with free buddies of equal size.
    for (i = lg; i < 7 && !give; i++) begin
      buddy = (off ^ (32 << i)) & (FRAME_BYTES - 1);
      if (hdr_mem[hidx(fid, buddy)] != i) break;
      if (i == 6) begin
        give = 1;
        break;
      end
      off &= buddy;
      hdr_mem[hidx(fid, off)] = 4'(i + 1);
    end
    // A wholly free frame leaves the list and goes back on the stack.
    if (give) begin
      for (i = slot; i + 1 < frame_total; i++) begin
        frame_list[i] = frame_list[i + 1];
        size_mask[i] = size_mask[i + 1];
      end
      frame_total--;
      if (spare_depth < NUM_FRAMES) begin
        spare_stack[spare_depth] = fid;
        spare_depth++;
      end
      return ST_OK;
    end
    return mask_rebuild(slot) ? ST_OK : ST_CORRUPT;
  endfunction

  function automatic logic [31:0] chunk_addr(chunk_t c);
    return cfg_base + c.frame * FRAME_BYTES + c.off + 1;
  endfunction

  // Clock and a single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  // Results are sampled mid-cycle, where the strobe is stable.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result transfer %h", result_address_o);
        mismatches++;
      end else begin
        outcome_t w;
        w = outcome_q.pop_front();
        if (w.addr !== result_address_o || w.st !== status_o ||
            w.cnt !== heap_frame_count_o) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected addr %h st %0d cnt %0d, got addr %h st %0d cnt %0d",
                     w.addr, w.st, w.cnt, result_address_o, status_o, heap_frame_count_o);
          mismatches++;
        end
      end
    end
  end

  // Issue one request, wait until it is taken and record its expected outcome.
  task automatic send(op_e op, int size, logic [31:0] addr, bit typed, outcome_t want);
    outcome_t    p;
    logic [31:0] a;
    status_e     s;
    chunk_t      c;
    start <= 1'b1;
    op_i <= op;
    alloc_size_i <= size[15:0];
    free_address_i <= addr;
    // Busy is looked at mid-cycle; the next rising edge then takes the request.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    a = '0;
    if (op == OP_FREE) s = heap_free(addr);
    else s = heap_alloc(size & 32'hFFFF, a);
    p = {a, s, frame_total[8:0]};
    outcome_q.push_back(typed ? want : p);
    if (op == OP_ALLOC && s == ST_OK) begin
      c.frame = (a - cfg_base) >> 12;
      c.off = ((a - cfg_base) & 32'hFFF) - 1;
      live_q.push_back(c);
      seen_q.push_back(c);
    end
    // Bursts of back-to-back requests separated by random gaps.
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MEMORY_BASE) cfg_base = value;
    else cfg_max = value[11:0];
  endtask

  // Random free: mostly live chunks, some double frees, some noise.
  task automatic random_free();
    logic [31:0] a, rel;
    int          k, r, in_frame, fid;
    bit          known;
    r = $urandom_range(0, 99);
    if (r < 80 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = chunk_addr(live_q[k]);
      live_q.delete(k);
    end else if (r < 86 && seen_q.size() != 0) begin
      a = chunk_addr(seen_q[$urandom_range(0, seen_q.size() - 1)]);
    end else if (r < 90) begin
      a = '0;
    end else begin
      a = $urandom();
      rel = a - cfg_base;
      in_frame = rel[11:0];
      fid = rel[31:12];
      known = 0;
      for (k = 0; k < frame_total; k++) if (frame_list[k] == fid) known = 1;
      // Never point at a slot that may not have been written.
      if (known && in_frame != 0 && ((in_frame - 1) & 31) == 0) a ^= 32'd2;
    end
    send(OP_FREE, $urandom_range(0, 65535), a, 0, '0);
  endtask

  task automatic random_alloc();
    int lg, size, r;
    r = $urandom_range(0, 99);
    lg = $urandom_range(0, 7);
    if (r < 3) size = 0;
    else if (r < 6) size = cfg_max;
    else if (r < 9) size = cfg_max + 1;
    else if (r < 12) size = $urandom_range(0, 65535);
    else size = $urandom_range(1, (32 << lg) - 1);
    send(OP_ALLOC, size, $urandom(), 0, '0);
  endtask

  initial begin
    int          p, n, k;
    row_t        rw;
    logic [31:0] a;
    start = 1'b0;
    op_i = 1'b0;
    alloc_size_i = '0;
    free_address_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    errors = 0;
    mismatches = 0;
    burst_left = 5;
    foreach (hdr_mem[k]) hdr_mem[k] = '0;
    foreach (frame_list[k]) begin
      frame_list[k] = 0;
      size_mask[k] = '0;
      spare_stack[k] = FIRST_FREE_FRAME + k;
    end
    frame_total = 0;
    spare_depth = STACK_RESET;
    cfg_base = '0;
    cfg_max = 4095;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table: errors, extremes and the first allocation are typed in.
    rows.push_back('{OP_ALLOC, 0, 0, 0, 1, {32'd0, ST_ZERO, 9'd0}});
    rows.push_back('{OP_ALLOC, 65535, 32'hFFFFFFFF, 0, 1, {32'd0, ST_BIG, 9'd0}});
    rows.push_back('{OP_ALLOC, 4096, 0, 0, 1, {32'd0, ST_BIG, 9'd0}});
    rows.push_back('{OP_FREE, 0, 0, 0, 1, {32'd0, ST_OK, 9'd0}});
    rows.push_back('{OP_FREE, 65535, 32'hFFFFFFFF, 0, 1, {32'd0, ST_ALIGN, 9'd0}});
    rows.push_back('{OP_FREE, 0, 32'h1000, 0, 1, {32'd0, ST_ALIGN, 9'd0}});
    rows.push_back('{OP_FREE, 0, 32'h5001, 0, 1, {32'd0, ST_UNKNOWN, 9'd0}});
    rows.push_back('{OP_ALLOC, 31, 0, 0, 1, {32'h000FF001, ST_OK, 9'd1}});
    rows.push_back('{OP_ALLOC, 32, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 1, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 4095, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 2047, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 63, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 127, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 255, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 511, 0, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 1023, 0, 0, 0, '0});
    rows.push_back('{OP_FREE, 0, 0, 1, 0, '0});
    rows.push_back('{OP_FREE, 0, 0, 1, 0, '0});
    rows.push_back('{OP_FREE, 0, 32'h000FF002, 0, 0, '0});
    rows.push_back('{OP_FREE, 0, 32'h000FF001, 0, 0, '0});
    rows.push_back('{OP_ALLOC, 4095, 0, 0, 0, '0});
    rows.push_back('{OP_FREE, 0, 0, 1, 0, '0});
    rows.push_back('{OP_FREE, 0, 0, 1, 0, '0});
    foreach (rows[k]) begin
      rw = rows[k];
      a = rw.addr;
      if (rw.free_last && live_q.size() != 0) a = chunk_addr(live_q.pop_back());
      send(rw.op, rw.size, a, rw.typed, rw.want);
    end

    // Random phases under several register settings, extremes included.
    for (p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: begin
          reg_write(REG_MEMORY_BASE, 32'hFFFFFFFF);
          reg_write(REG_MAX_ALLOC, 32'd1);
        end
        1: begin
          reg_write(REG_MEMORY_BASE, $urandom());
          reg_write(REG_MAX_ALLOC, $urandom_range(1, 4095));
        end
        2: begin
          reg_write(REG_MEMORY_BASE, 32'd0);
          reg_write(REG_MAX_ALLOC, 32'd4095);
        end
        3: begin
          reg_write(REG_MEMORY_BASE, $urandom() & 32'hFFFFF000);
          reg_write(REG_MAX_ALLOC, 32'd4095);
        end
        default: begin
          reg_write(REG_MEMORY_BASE, $urandom());
          reg_write(REG_MAX_ALLOC, $urandom_range(1024, 4095));
        end
      endcase
      if (p == 3) begin
        // Use up every frame, then hand them all back.
        for (n = 0; n < 250; n++) send(OP_ALLOC, $urandom_range(4000, 4095), 0, 0, '0);
        while (live_q.size() != 0) begin
          k = $urandom_range(0, live_q.size() - 1);
          a = chunk_addr(live_q[k]);
          live_q.delete(k);
          send(OP_FREE, 0, a, 0, '0);
        end
      end else begin
        for (n = 0; n < 70; n++)
          if ($urandom_range(0, 99) < 50) random_alloc();
          else random_free();
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bha_pkg.sv
rtl/bha_engine.sv
rtl/buddy_heap_allocator_top.sv
tb/tb.sv
